### rtl/core/ppfc_pkg.sv
// ----------------------------------------------------------------------------
// ppfc_pkg
// Shared types and constants for the packet parser with Fletcher check.
// ----------------------------------------------------------------------------
package ppfc_pkg;

  localparam int MAX_PAYLOAD_DEF = 1024;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_W           = 11;
  localparam logic [CFG_W-1:0] CFG_LEN_RESET = 11'd1024;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_LONG     = 2'd3
  } status_t;

  typedef struct packed {
    logic        has_pl;
    logic [7:0]  pl_byte;
    logic [9:0]  pl_index;
    logic        has_sum;
    logic [7:0]  pkt_type;
    logic [7:0]  pkt_flags;
    logic [63:0] timestamp;
    logic [15:0] pl_length;
    status_t     status;
  } ppfc_entry_t;

endpackage

### rtl/core/ppfc_if.sv
// ----------------------------------------------------------------------------
// ppfc interfaces
// Valid/ready channels for input bytes, result items and configuration.
// ----------------------------------------------------------------------------
interface ppfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_block;

  modport source (output valid, output data_byte, output end_of_block, input ready);
  modport sink   (input valid, input data_byte, input end_of_block, output ready);
endinterface

interface ppfc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [9:0]  payload_index;
  logic [7:0]  packet_type;
  logic [7:0]  packet_flags;
  logic [63:0] timestamp;
  logic [15:0] payload_length;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output kind, output payload_byte, output payload_index,
                  output packet_type, output packet_flags, output timestamp,
                  output payload_length, output status, output last, input ready);
  modport sink   (input valid, input kind, input payload_byte, input payload_index,
                  input packet_type, input packet_flags, input timestamp,
                  input payload_length, input status, input last, output ready);
endinterface

interface ppfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] max_payload_length;

  modport source (output valid, output max_payload_length, input ready);
  modport sink   (input valid, input max_payload_length, output ready);
endinterface

### rtl/core/packet_parser_fletcher_check.sv
// ----------------------------------------------------------------------------
// packet_parser_fletcher_check
// Streaming packet parser with Fletcher-style check word verification (sums modulo 256).
// ----------------------------------------------------------------------------
// in_chan carries one byte of a deframed block per transaction; end_of_block
// marks its final byte. Each payload byte yields a kind 0 transaction on
// out_chan; the final byte also yields a kind 1 summary with type, flags,
// timestamp, length and status (ok, too short, check mismatch, too long).
// cfg_chan writes max_payload_length; it is always ready. The user must write
// it only while the block is idle; the block itself does not enforce this.
// An accepted input transaction reaches out_chan through the queue write and
// then the output register. Throughput: one byte per cycle while the queue
// is not full; the output register issues one transaction per cycle while
// out_chan is ready, so a byte that gives both a payload and a summary takes
// two output transactions, absorbed by a four-entry queue between parser and
// output stage.
// When out_chan stalls, the queue fills and in_chan ready drops once full.
// Reset clears the parser to expect a type byte, empties the queue and sets
// max_payload_length to 1024.
// ----------------------------------------------------------------------------
module packet_parser_fletcher_check #(
  parameter int MAX_PAYLOAD = ppfc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ppfc_in_if.sink     in_chan,
  ppfc_out_if.source  out_chan,
  ppfc_cfg_if.sink    cfg_chan
);
  import ppfc_pkg::*;

  logic [CFG_W-1:0] max_len_r;
  ppfc_entry_t      wr_entry, rd_entry;
  logic             push, pop, full, empty;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= CFG_LEN_RESET;
    end else if (cfg_chan.valid) begin
      max_len_r <= cfg_chan.max_payload_length;
    end
  end

  ppfc_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .max_len (max_len_r),
    .in_s    (in_chan),
    .q_full  (full),
    .q_push  (push),
    .q_entry (wr_entry)
  );

  ppfc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .pop      (pop),
    .rd_entry (rd_entry),
    .empty    (empty)
  );

  ppfc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (rd_entry),
    .q_empty (empty),
    .q_pop   (pop),
    .out_s   (out_chan)
  );

endmodule

### rtl/core/ppfc_front.sv
// ----------------------------------------------------------------------------
// ppfc_front
// Byte parser: field phases, Fletcher sums, queue entries for payload and final bytes.
// ----------------------------------------------------------------------------
module ppfc_front #(
  parameter int MAX_PAYLOAD = ppfc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [10:0]          max_len,
  ppfc_in_if.sink              in_s,
  input  logic                 q_full,
  output logic                 q_push,
  output ppfc_pkg::ppfc_entry_t q_entry
);
  import ppfc_pkg::*;

  localparam int DW = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [2:0] {
    PH_TYPE, PH_FLAGS, PH_TS, PH_LEN, PH_DATA, PH_CHECK, PH_DONE
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [3:0]      ts_cnt_r, ts_cnt_nxt;
  logic            sel_r, sel_nxt;
  logic [DW-1:0]   data_cnt_r, data_cnt_nxt;
  logic [7:0]      s0_r, s0_nxt, s1_r, s1_nxt;
  logic [7:0]      type_r, type_nxt, flags_r, flags_nxt;
  logic [63:0]     ts_r, ts_nxt;
  logic [15:0]     len_r, len_nxt, rcv_r, rcv_nxt, chk_r, chk_nxt;
  logic            exc_r, exc_nxt;

  logic            take, emit_pl;
  logic [7:0]      b, s0_upd, s1_upd;
  logic [15:0]     chk_calc, lim, len_full;
  logic [4:0]      ts_inc;
  logic [DW:0]     data_inc;
  status_t         st;

  assign b          = in_s.data_byte;
  assign in_s.ready = !q_full;
  assign take       = in_s.valid && !q_full;
  assign s0_upd     = s0_r + b;
  assign s1_upd     = s1_r + s0_upd;
  assign chk_calc   = {s0_upd - s1_upd, s1_upd - {s0_upd[6:0], 1'b0}};
  assign lim        = (16'(max_len) > 16'(MAX_PAYLOAD)) ? 16'(MAX_PAYLOAD) : 16'(max_len);
  assign len_full   = {len_r[15:8], b};
  assign ts_inc     = {1'b0, ts_cnt_r} + 5'd1;
  assign data_inc   = {1'b0, data_cnt_r} + (DW+1)'(1);

  always_comb begin
    phase_nxt    = phase_r;
    ts_cnt_nxt   = ts_cnt_r;
    sel_nxt      = sel_r;
    data_cnt_nxt = data_cnt_r;
    s0_nxt       = s0_r;
    s1_nxt       = s1_r;
    type_nxt     = type_r;
    flags_nxt    = flags_r;
    ts_nxt       = ts_r;
    len_nxt      = len_r;
    rcv_nxt      = rcv_r;
    chk_nxt      = chk_r;
    exc_nxt      = exc_r;
    emit_pl      = 1'b0;

    if (phase_r != PH_CHECK && phase_r != PH_DONE) begin
      s0_nxt = s0_upd;
      s1_nxt = s1_upd;
    end

    unique case (phase_r)
      PH_TYPE: begin
        type_nxt  = b;
        phase_nxt = PH_FLAGS;
      end
      PH_FLAGS: begin
        flags_nxt  = b;
        ts_cnt_nxt = '0;
        phase_nxt  = (b[3:0] != 4'd0) ? PH_TS : PH_LEN;
      end
      PH_TS: begin
        if (!ts_cnt_r[3]) ts_nxt[{ts_cnt_r[2:0], 3'b000} +: 8] = b;
        if (ts_inc >= {1'b0, flags_r[3:0]}) begin
          ts_cnt_nxt = '0;
          phase_nxt  = PH_LEN;
        end else begin
          ts_cnt_nxt = ts_inc[3:0];
        end
      end
      PH_LEN: begin
        if (!sel_r) begin
          len_nxt = {b, 8'h00};
          sel_nxt = 1'b1;
        end else begin
          len_nxt      = len_full;
          sel_nxt      = 1'b0;
          data_cnt_nxt = '0;
          if (len_full > lim) begin
            exc_nxt   = 1'b1;
            phase_nxt = PH_DONE;
          end else if (len_full == 16'd0) begin
            chk_nxt   = chk_calc;
            phase_nxt = PH_CHECK;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        emit_pl = 1'b1;
        if (data_inc >= (DW+1)'(len_r)) begin
          chk_nxt      = chk_calc;
          phase_nxt    = PH_CHECK;
          data_cnt_nxt = '0;
        end else begin
          data_cnt_nxt = data_inc[DW-1:0];
        end
      end
      PH_CHECK: begin
        if (!sel_r) begin
          rcv_nxt = {b, 8'h00};
          sel_nxt = 1'b1;
        end else begin
          rcv_nxt   = {rcv_r[15:8], b};
          sel_nxt   = 1'b0;
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    priority if (exc_nxt)               st = ST_LONG;
    else if (phase_nxt != PH_DONE)      st = ST_SHORT;
    else if (rcv_nxt == chk_nxt)        st = ST_OK;
    else                                st = ST_MISMATCH;
  end

  always_comb begin
    q_entry.has_pl    = emit_pl;
    q_entry.pl_byte   = b;
    q_entry.pl_index  = 10'(data_cnt_r);
    q_entry.has_sum   = in_s.end_of_block;
    q_entry.pkt_type  = type_nxt;
    q_entry.pkt_flags = flags_nxt;
    q_entry.timestamp = ts_nxt;
    q_entry.pl_length = len_nxt;
    q_entry.status    = st;
  end

  assign q_push = take && (emit_pl || in_s.end_of_block);

  always_ff @(posedge clk) begin
    if (!rst_n || (take && in_s.end_of_block)) begin
      phase_r    <= PH_TYPE;
      ts_cnt_r   <= '0;
      sel_r      <= 1'b0;
      data_cnt_r <= '0;
      s0_r       <= '0;
      s1_r       <= '0;
      type_r     <= '0;
      flags_r    <= '0;
      ts_r       <= '0;
      len_r      <= '0;
      rcv_r      <= '0;
      chk_r      <= '0;
      exc_r      <= 1'b0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      ts_cnt_r   <= ts_cnt_nxt;
      sel_r      <= sel_nxt;
      data_cnt_r <= data_cnt_nxt;
      s0_r       <= s0_nxt;
      s1_r       <= s1_nxt;
      type_r     <= type_nxt;
      flags_r    <= flags_nxt;
      ts_r       <= ts_nxt;
      len_r      <= len_nxt;
      rcv_r      <= rcv_nxt;
      chk_r      <= chk_nxt;
      exc_r      <= exc_nxt;
    end
  end

endmodule

### rtl/core/ppfc_fifo.sv
// ----------------------------------------------------------------------------
// ppfc_fifo
// Short entry queue between parser and output stage.
// ----------------------------------------------------------------------------
module ppfc_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ppfc_pkg::ppfc_entry_t wr_entry,
  output logic                  full,
  input  logic                  pop,
  output ppfc_pkg::ppfc_entry_t rd_entry,
  output logic                  empty
);
  import ppfc_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  ppfc_entry_t mem [QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full     = (cnt_r == (AW+1)'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign rd_entry = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (pop)  rp_r <= (rp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + AW'(1);
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (AW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (AW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

### rtl/core/ppfc_back.sv
// ----------------------------------------------------------------------------
// ppfc_back
// Output stage: splits queue entries into payload and summary transactions.
// ----------------------------------------------------------------------------
module ppfc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ppfc_pkg::ppfc_entry_t head,
  input  logic                  q_empty,
  output logic                  q_pop,
  ppfc_out_if.source            out_s
);
  import ppfc_pkg::*;

  logic        valid_r, pl_done_r;
  logic        kind_r, last_r;
  logic [7:0]  byte_r, type_r, flags_r;
  logic [9:0]  index_r;
  logic [63:0] ts_r;
  logic [15:0] len_r;
  logic [1:0]  status_r;
  logic        load, pl_first;

  assign load     = !q_empty && (!valid_r || out_s.ready);
  assign pl_first = head.has_pl && !pl_done_r;
  assign q_pop    = load && !(pl_first && head.has_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      pl_done_r <= 1'b0;
    end else begin
      if (load)             valid_r <= 1'b1;
      else if (out_s.ready) valid_r <= 1'b0;
      if (load)             pl_done_r <= pl_first && head.has_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pl_first) begin
        kind_r   <= KIND_PAYLOAD;
        byte_r   <= head.pl_byte;
        index_r  <= head.pl_index;
        type_r   <= '0;
        flags_r  <= '0;
        ts_r     <= '0;
        len_r    <= '0;
        status_r <= ST_OK;
        last_r   <= 1'b0;
      end else begin
        kind_r   <= KIND_SUMMARY;
        byte_r   <= '0;
        index_r  <= '0;
        type_r   <= head.pkt_type;
        flags_r  <= head.pkt_flags;
        ts_r     <= head.timestamp;
        len_r    <= head.pl_length;
        status_r <= head.status;
        last_r   <= 1'b1;
      end
    end
  end

  assign out_s.valid          = valid_r;
  assign out_s.kind           = kind_r;
  assign out_s.payload_byte   = byte_r;
  assign out_s.payload_index  = index_r;
  assign out_s.packet_type    = type_r;
  assign out_s.packet_flags   = flags_r;
  assign out_s.timestamp      = ts_r;
  assign out_s.payload_length = len_r;
  assign out_s.status         = status_r;
  assign out_s.last           = last_r;

  a_split_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pl_done_r |-> !q_empty)
    else $error("summary pending without queue entry");
  a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ((kind_r == KIND_SUMMARY) == last_r))
    else $error("kind and last disagree");

endmodule
